// File: design/command_frame_receiver_assert.svh
// Assertion macros for the command frame receiver.
// Included by the RTL file that carries concurrent assertions; no dependencies.
`ifndef COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFR_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/cfr_pkg.sv
// Shared constants, types and state encoding of the command frame receiver.
// Used by the other files of the block but cfr_ram and the assertion header; depends on nothing.
package cfr_pkg;

	localparam int BYTE_W        = 8;
	localparam int ACTION_W      = 3;
	localparam int MAX_PAYLOAD   = 32;
	localparam int ID_LEN        = 12;
	localparam int RSP_HDR_BYTES = 4;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;
	localparam int ID_HIGH_W  = 64;
	localparam int ID_LOW_W   = 32;

	localparam int RLEN_MAX = (MAX_PAYLOAD > ID_LEN) ? MAX_PAYLOAD : ID_LEN;
	localparam int LEN_W    = $clog2(MAX_PAYLOAD + 1);
	localparam int RLEN_W   = $clog2(RLEN_MAX + 1);
	localparam int EIDX_W   = $clog2(RLEN_MAX + RSP_HDR_BYTES + 3);
	localparam int ADDR_W   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int ID_IDX_W = $clog2(ID_LEN);
	localparam int ID_SLOTS = 2 ** ID_IDX_W;
	localparam int ID_PAD_W = (ID_SLOTS - ID_LEN) * BYTE_W;

	localparam logic [BYTE_W-1:0] HEAD_BYTE       = 8'hAA;
	localparam logic [BYTE_W-1:0] TAIL_BYTE       = 8'h55;
	localparam logic [BYTE_W-1:0] ID_CMD          = 8'h00;
	localparam logic [BYTE_W-1:0] FIRST_ACTION_CMD = 8'h01;
	localparam logic [BYTE_W-1:0] LAST_ACTION_CMD = 8'h04;

	localparam logic [ACTION_W-1:0] ACT_NONE = 3'd0;

	localparam logic [CFG_IDX_W-1:0] REG_ID_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ID_LOW  = 1'b1;

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_HDR2,
		ST_CMD,
		ST_LEN,
		ST_PAYLOAD,
		ST_CHK,
		ST_TAIL1,
		ST_TAIL2,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap_cmd;
		logic cap_len;
		logic wr_pay;
		logic cap_chk;
		logic start_emit;
		logic load_out;
	} cfr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_head;
		logic is_tail;
		logic len_bad;
		logic len_zero;
		logic pay_last;
		logic sum_ok;
		logic out_free;
		logic emit_last;
	} cfr_stat_t;

endpackage

// File: design/cfr_intf.sv
// Stream interfaces of the command frame receiver: received bytes in,
// response bytes out. Depends on cfr_pkg.
interface cfr_rx_if;
	logic                        valid;
	logic                        ready;
	logic [cfr_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_tx_if;
	logic                          valid;
	logic                          ready;
	logic [cfr_pkg::BYTE_W-1:0]    tx_byte;
	logic                          last_byte;
	logic [cfr_pkg::ACTION_W-1:0]  action;

	modport source (output valid, output tx_byte, output last_byte, output action, input ready);
	modport sink   (input valid, input tx_byte, input last_byte, input action, output ready);
endinterface

// File: design/cfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/cfr_ctrl.sv
// Frame controller: walks header, command, length, payload, checksum, tail
// and response emission. Depends on cfr_pkg.
module cfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_ready,
	input  cfr_pkg::cfr_stat_t stat,
	output cfr_pkg::cfr_cmd_t  cmd
);

	cfr_pkg::state_t state_q, state_d;
	logic            fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfr_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	assign fire = rx_valid && rx_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfr_pkg::ST_HUNT: begin
				if (fire && stat.is_head) state_d = cfr_pkg::ST_HDR2;
			end
			cfr_pkg::ST_HDR2: begin
				if (fire) state_d = stat.is_head ? cfr_pkg::ST_CMD : cfr_pkg::ST_HUNT;
			end
			cfr_pkg::ST_CMD: begin
				if (fire) state_d = cfr_pkg::ST_LEN;
			end
			cfr_pkg::ST_LEN: begin
				if (fire) begin
					if (stat.len_bad) state_d = cfr_pkg::ST_HUNT;
					else if (stat.len_zero) state_d = cfr_pkg::ST_CHK;
					else state_d = cfr_pkg::ST_PAYLOAD;
				end
			end
			cfr_pkg::ST_PAYLOAD: begin
				if (fire && stat.pay_last) state_d = cfr_pkg::ST_CHK;
			end
			cfr_pkg::ST_CHK: begin
				if (fire) state_d = cfr_pkg::ST_TAIL1;
			end
			cfr_pkg::ST_TAIL1: begin
				if (fire) state_d = stat.is_tail ? cfr_pkg::ST_TAIL2 : cfr_pkg::ST_HUNT;
			end
			cfr_pkg::ST_TAIL2: begin
				if (fire) begin
					state_d = (stat.is_tail && stat.sum_ok) ? cfr_pkg::ST_EMIT
					                                        : cfr_pkg::ST_HUNT;
				end
			end
			cfr_pkg::ST_EMIT: begin
				if (stat.out_free && stat.emit_last) state_d = cfr_pkg::ST_HUNT;
			end
			default: state_d = cfr_pkg::ST_HUNT;
		endcase
	end

	always_comb begin
		rx_ready       = (state_q != cfr_pkg::ST_EMIT);
		cmd.cap_cmd    = fire && (state_q == cfr_pkg::ST_CMD);
		cmd.cap_len    = fire && (state_q == cfr_pkg::ST_LEN) && !stat.len_bad;
		cmd.wr_pay     = fire && (state_q == cfr_pkg::ST_PAYLOAD);
		cmd.cap_chk    = fire && (state_q == cfr_pkg::ST_CHK);
		cmd.start_emit = fire && (state_q == cfr_pkg::ST_TAIL2) && stat.is_tail && stat.sum_ok;
		cmd.load_out   = (state_q == cfr_pkg::ST_EMIT) && stat.out_free;
	end

endmodule

// File: design/cfr_dp.sv
// Frame datapath: captured fields, running sum, payload RAM, device ID
// registers, response byte selection and the output register.
// Depends on cfr_pkg, cfr_ram and the assertion macro header.
`include "command_frame_receiver_assert.svh"

module cfr_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cfr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [cfr_pkg::BYTE_W-1:0]        rx_byte,
	input  cfr_pkg::cfr_cmd_t                 cmd,
	output cfr_pkg::cfr_stat_t                stat,
	output logic                              tx_valid,
	input  logic                              tx_ready,
	output logic [cfr_pkg::BYTE_W-1:0]        tx_byte,
	output logic                              tx_last,
	output logic [cfr_pkg::ACTION_W-1:0]      tx_action
);

	logic [cfr_pkg::BYTE_W-1:0]    cmd_q;
	logic [cfr_pkg::LEN_W-1:0]     len_q;
	logic [cfr_pkg::BYTE_W-1:0]    chk_q;
	logic [cfr_pkg::BYTE_W-1:0]    sum_q;
	logic [cfr_pkg::LEN_W-1:0]     pay_idx_q;
	logic [cfr_pkg::EIDX_W-1:0]    eidx_q;
	logic [cfr_pkg::ID_HIGH_W-1:0] id_hi_q;
	logic [cfr_pkg::ID_LOW_W-1:0]  id_lo_q;
	logic                          tx_valid_q;
	logic [cfr_pkg::BYTE_W-1:0]    tx_byte_q;
	logic                          tx_last_q;
	logic [cfr_pkg::ACTION_W-1:0]  tx_action_q;

	logic [cfr_pkg::LEN_W-1:0]     pay_next;
	logic [cfr_pkg::RLEN_W-1:0]    rlen;
	logic [cfr_pkg::EIDX_W-1:0]    pay_end;
	logic [cfr_pkg::EIDX_W-1:0]    eidx_look;
	logic [cfr_pkg::EIDX_W-1:0]    rd_pos;
	logic [cfr_pkg::EIDX_W-1:0]    id_pos;
	logic [cfr_pkg::BYTE_W-1:0]    ram_rdata;
	logic [cfr_pkg::ID_SLOTS*cfr_pkg::BYTE_W-1:0] id_pad;
	logic [cfr_pkg::BYTE_W-1:0]    id_bytes [cfr_pkg::ID_SLOTS];
	logic [cfr_pkg::BYTE_W-1:0]    pay_byte;
	logic [cfr_pkg::BYTE_W-1:0]    emit_byte;
	logic                          in_payload;
	logic                          is_action;
	logic                          is_id;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_hi_q <= '0;
			id_lo_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfr_pkg::REG_ID_HIGH: id_hi_q <= cfg_data;
				cfr_pkg::REG_ID_LOW:  id_lo_q <= cfg_data[cfr_pkg::ID_LOW_W-1:0];
			endcase
		end
	end

	assign is_id    = (cmd_q == cfr_pkg::ID_CMD);
	assign rlen     = is_id ? cfr_pkg::RLEN_W'(cfr_pkg::ID_LEN) : cfr_pkg::RLEN_W'(len_q);
	assign pay_next = pay_idx_q + cfr_pkg::LEN_W'(1);
	assign pay_end  = cfr_pkg::EIDX_W'(cfr_pkg::RSP_HDR_BYTES) + cfr_pkg::EIDX_W'(rlen);

	// The RAM address looks one byte ahead when the output register loads, so
	// the registered read data always belongs to the current emit index.
	assign eidx_look = cmd.load_out ? eidx_q + cfr_pkg::EIDX_W'(1) : eidx_q;
	assign rd_pos    = eidx_look - cfr_pkg::EIDX_W'(cfr_pkg::RSP_HDR_BYTES);
	assign id_pos    = eidx_q - cfr_pkg::EIDX_W'(cfr_pkg::RSP_HDR_BYTES);

	cfr_ram #(
		.WIDTH (cfr_pkg::BYTE_W),
		.DEPTH (cfr_pkg::MAX_PAYLOAD)
	) u_pay_ram (
		.clk   (clk),
		.we    (cmd.wr_pay),
		.waddr (pay_idx_q[cfr_pkg::ADDR_W-1:0]),
		.wdata (rx_byte),
		.raddr (rd_pos[cfr_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// Device ID as bytes in transmit order, first word most significant.
	assign id_pad = {id_hi_q, id_lo_q, {cfr_pkg::ID_PAD_W{1'b0}}};

	always_comb begin
		for (int i = 0; i < cfr_pkg::ID_SLOTS; i++) begin
			id_bytes[i] = id_pad[cfr_pkg::BYTE_W*(cfr_pkg::ID_SLOTS-1-i) +: cfr_pkg::BYTE_W];
		end
	end

	assign pay_byte = is_id ? id_bytes[id_pos[cfr_pkg::ID_IDX_W-1:0]] : ram_rdata;

	always_comb begin
		in_payload = 1'b0;
		if (eidx_q < cfr_pkg::EIDX_W'(2)) begin
			emit_byte = cfr_pkg::HEAD_BYTE;
		end else if (eidx_q == cfr_pkg::EIDX_W'(2)) begin
			emit_byte = cmd_q;
		end else if (eidx_q == cfr_pkg::EIDX_W'(3)) begin
			emit_byte = cfr_pkg::BYTE_W'(rlen);
		end else if (eidx_q < pay_end) begin
			emit_byte  = pay_byte;
			in_payload = 1'b1;
		end else if (eidx_q == pay_end) begin
			emit_byte = sum_q;
		end else begin
			emit_byte = cfr_pkg::TAIL_BYTE;
		end
	end

	assign is_action = (cmd_q >= cfr_pkg::FIRST_ACTION_CMD) &&
	                   (cmd_q <= cfr_pkg::LAST_ACTION_CMD);

	// Frame fields and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= '0;
			len_q     <= '0;
			chk_q     <= '0;
			sum_q     <= '0;
			pay_idx_q <= '0;
			eidx_q    <= '0;
		end else begin
			if (cmd.cap_cmd) begin
				cmd_q <= rx_byte;
				sum_q <= rx_byte;
			end
			if (cmd.cap_len) begin
				len_q     <= rx_byte[cfr_pkg::LEN_W-1:0];
				sum_q     <= sum_q + rx_byte;
				pay_idx_q <= '0;
			end
			if (cmd.wr_pay) begin
				sum_q     <= sum_q + rx_byte;
				pay_idx_q <= pay_next;
			end
			if (cmd.cap_chk) begin
				chk_q <= rx_byte;
			end
			// The sum register is reused for the response checksum.
			if (cmd.start_emit) begin
				sum_q  <= cmd_q + cfr_pkg::BYTE_W'(rlen);
				eidx_q <= '0;
			end
			if (cmd.load_out) begin
				eidx_q <= eidx_q + cfr_pkg::EIDX_W'(1);
				if (in_payload) begin
					sum_q <= sum_q + pay_byte;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			tx_valid_q <= 1'b1;
		end else if (tx_ready) begin
			tx_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			tx_byte_q   <= emit_byte;
			tx_last_q   <= stat.emit_last;
			tx_action_q <= (stat.emit_last && is_action) ? cmd_q[cfr_pkg::ACTION_W-1:0]
			                                             : cfr_pkg::ACT_NONE;
		end
	end

	assign tx_valid  = tx_valid_q;
	assign tx_byte   = tx_byte_q;
	assign tx_last   = tx_last_q;
	assign tx_action = tx_action_q;

	always_comb begin
		stat.is_head   = (rx_byte == cfr_pkg::HEAD_BYTE);
		stat.is_tail   = (rx_byte == cfr_pkg::TAIL_BYTE);
		stat.len_bad   = (rx_byte > cfr_pkg::BYTE_W'(cfr_pkg::MAX_PAYLOAD));
		stat.len_zero  = (rx_byte == '0);
		stat.pay_last  = (pay_next == len_q);
		stat.sum_ok    = (sum_q == chk_q);
		stat.out_free  = !tx_valid_q || tx_ready;
		stat.emit_last = (eidx_q == pay_end + cfr_pkg::EIDX_W'(2));
	end

	`CFR_ASSERT_IMPL(a_last_is_tail, clk, arst_n, tx_valid_q && tx_last_q,
		tx_byte_q == cfr_pkg::TAIL_BYTE, "final response byte is not a tail byte")
	`CFR_ASSERT_IMPL(a_action_on_last, clk, arst_n, tx_valid_q && (tx_action_q != cfr_pkg::ACT_NONE),
		tx_last_q, "action code outside the final response byte")
	`CFR_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.load_out,
		!tx_valid_q || tx_ready, "output register loaded while still full")
	`CFR_ASSERT_IMPL(a_pay_in_range, clk, arst_n, cmd.wr_pay,
		pay_idx_q < len_q, "payload write beyond the frame length")

endmodule

// File: design/command_frame_receiver.sv
// Command frame receiver top level: controller, datapath and stream ports.
// Depends on cfr_pkg, cfr_intf (cfr_rx_if, cfr_tx_if), cfr_ctrl and cfr_dp.
//
// Usage: received bytes enter on rx, one per request. The block hunts for
// the header AA AA, then takes command, length, payload, checksum and two
// 55 tail bytes. A frame with a length above the maximum, a bad tail byte or
// a checksum that does not match the byte sum is dropped without a response.
// A good frame yields a response AA AA cmd len payload chk 55 55 on tx, one
// byte per request; command 0 answers with the 12-byte device ID, others echo
// the payload. The final byte carries last_byte and, for commands 1 to 4, the
// action code. After the second tail byte is taken, the controller enters its
// emit state and the first response byte is then loaded into the output
// register; the response streams at one byte per cycle while tx is ready,
// response length + 7 bytes in all, paced by the response byte counter and the
// payload RAM's registered read port. rx is not ready until the last response
// byte has entered the output register. A stalled tx holds the output register
// and the counter. Reset returns the parser to header hunting and clears both
// device ID registers; the payload RAM needs no clearing. The ID registers are
// written through cfg_we, cfg_index and cfg_data.
module command_frame_receiver (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfr_pkg::CFG_DATA_W-1:0] cfg_data,
	cfr_rx_if.sink                         rx,
	cfr_tx_if.source                       tx
);

	cfr_pkg::cfr_cmd_t  cmd;
	cfr_pkg::cfr_stat_t stat;

	// The controller sequences the frame fields and the response bytes.
	cfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the frame fields, the payload and the output register.
	cfr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.stat      (stat),
		.tx_valid  (tx.valid),
		.tx_ready  (tx.ready),
		.tx_byte   (tx.tx_byte),
		.tx_last   (tx.last_byte),
		.tx_action (tx.action)
	);

endmodule

// File: sim/cfr_response_check.sv
`timescale 1ns / 100ps
// Response checker for the command frame receiver: watches the register port
// and both byte streams, predicts the response frames and compares them.
// Depends on cfr_pkg only; it is fed plain signals by the testbench top.
module cfr_response_check
	import cfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  rx_valid,
	input  logic                  rx_ready,
	input  logic [BYTE_W-1:0]     rx_byte,
	input  logic                  tx_valid,
	input  logic                  tx_ready,
	input  logic [BYTE_W-1:0]     tx_byte,
	input  logic                  tx_last,
	input  logic [ACTION_W-1:0]   tx_action,
	output int unsigned           failures,
	output int unsigned           bytes_owed,
	output int unsigned           bytes_checked
);

	typedef struct packed {
		logic [BYTE_W-1:0]   data;
		logic                last;
		logic [ACTION_W-1:0] act;
	} rsp_byte_t;

	// Shadow copy of the device ID and of the frame parser.
	logic [ID_HIGH_W-1:0] id_high;
	logic [ID_LOW_W-1:0]  id_low;
	logic                 in_frame;
	logic                 hdr_seen;
	logic [5:0]           pos;
	logic [BYTE_W-1:0]    cmd_code;
	logic [5:0]           frame_len;
	logic [BYTE_W-1:0]    rx_chk;
	logic [BYTE_W-1:0]    run_sum;
	logic [BYTE_W-1:0]    payload [MAX_PAYLOAD];

	rsp_byte_t   response_q[$];
	rsp_byte_t   want;
	int unsigned errs;
	int unsigned checked;

	function automatic rsp_byte_t rsp_byte(input logic [BYTE_W-1:0] d, input logic last,
		input logic [ACTION_W-1:0] act);
		rsp_byte_t r;
		r.data = d;
		r.last = last;
		r.act  = act;
		return r;
	endfunction

	task automatic queue_response();
		int unsigned       rlen;
		int unsigned       k;
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] p;
		logic [ACTION_W-1:0] act;
		rlen = (cmd_code == ID_CMD) ? ID_LEN : frame_len;
		response_q.push_back(rsp_byte(HEAD_BYTE, 1'b0, ACT_NONE));
		response_q.push_back(rsp_byte(HEAD_BYTE, 1'b0, ACT_NONE));
		response_q.push_back(rsp_byte(cmd_code, 1'b0, ACT_NONE));
		response_q.push_back(rsp_byte(8'(rlen), 1'b0, ACT_NONE));
		sum = cmd_code + 8'(rlen);
		for (k = 0; k < rlen; k++) begin
			if (cmd_code != ID_CMD)
				p = payload[k];
			else if (k < 8)
				p = id_high[8*(7-k) +: 8];
			else
				p = id_low[8*(11-k) +: 8];
			sum = sum + p;
			response_q.push_back(rsp_byte(p, 1'b0, ACT_NONE));
		end
		act = (cmd_code >= FIRST_ACTION_CMD && cmd_code <= LAST_ACTION_CMD) ?
			cmd_code[ACTION_W-1:0] : ACT_NONE;
		response_q.push_back(rsp_byte(sum, 1'b0, ACT_NONE));
		response_q.push_back(rsp_byte(TAIL_BYTE, 1'b0, ACT_NONE));
		response_q.push_back(rsp_byte(TAIL_BYTE, 1'b1, act));
	endtask

	task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
		int   len;
		logic close;
		len   = frame_len;
		close = 1'b0;
		if (!in_frame) begin
			if (b == HEAD_BYTE && hdr_seen) begin
				in_frame = 1'b1;
				hdr_seen = 1'b0;
				pos      = '0;
			end else begin
				hdr_seen = (b == HEAD_BYTE);
			end
		end else begin
			if (pos == 0) begin
				cmd_code = b;
				run_sum  = b;
			end else if (pos == 1) begin
				if (b > MAX_PAYLOAD) begin
					close = 1'b1;
				end else begin
					frame_len = b[5:0];
					run_sum   = run_sum + b;
				end
			end else if (pos < 2 + len) begin
				payload[pos - 2] = b;
				run_sum = run_sum + b;
			end else if (pos == 2 + len) begin
				rx_chk = b;
			end else if (pos == 3 + len) begin
				close = (b != TAIL_BYTE);
			end else begin
				if (b == TAIL_BYTE && run_sum == rx_chk)
					queue_response();
				close = 1'b1;
			end
			if (close) begin
				in_frame = 1'b0;
				hdr_seen = 1'b0;
				pos      = '0;
			end else begin
				pos = pos + 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_high   = '0;
			id_low    = '0;
			in_frame  = 1'b0;
			hdr_seen  = 1'b0;
			pos       = '0;
			cmd_code  = '0;
			frame_len = '0;
			rx_chk    = '0;
			run_sum   = '0;
			foreach (payload[i])
				payload[i] = '0;
			response_q.delete();
			errs    = 0;
			checked = 0;
			failures      <= 0;
			bytes_owed    <= 0;
			bytes_checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ID_HIGH: id_high = cfg_data;
					REG_ID_LOW:  id_low  = cfg_data[ID_LOW_W-1:0];
					default: ;
				endcase
			end
			if (tx_valid && tx_ready) begin
				if (response_q.size() == 0) begin
					$display("%0t: unexpected response byte %02h (last %b, action %0d)",
						$time, tx_byte, tx_last, tx_action);
					errs++;
				end else begin
					want = response_q.pop_front();
					if (tx_byte !== want.data) begin
						$display("%0t: tx_byte expected %02h, got %02h",
							$time, want.data, tx_byte);
						errs++;
					end
					if (tx_last !== want.last) begin
						$display("%0t: last_byte expected %b, got %b (byte %02h)",
							$time, want.last, tx_last, want.data);
						errs++;
					end
					if (tx_action !== want.act) begin
						$display("%0t: action expected %0d, got %0d",
							$time, want.act, tx_action);
						errs++;
					end
					checked++;
				end
			end
			if (rx_valid && rx_ready)
				parse_rx_byte(rx_byte);
			failures      <= errs;
			bytes_owed    <= response_q.size();
			bytes_checked <= checked;
		end
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Top of the command frame receiver testbench: clock, reset, register writes,
// request stimulus and the verdict. Depends on cfr_pkg, the RTL's stream
// interfaces, the block itself and cfr_response_check.
module testbench;
	import cfr_pkg::*;

	// Ways in which a generated frame may be broken on purpose.
	typedef enum int {
		FR_GOOD      = 0,
		FR_BAD_SUM   = 1,
		FR_BAD_TAIL1 = 2,
		FR_BAD_TAIL2 = 3,
		FR_BIG_LEN   = 4
	} frame_fault_t;

	localparam int PHASE_BYTES = 25;
	localparam int SETTLE_CYCLES = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfr_rx_if rx_ch ();
	cfr_tx_if tx_ch ();

	int unsigned failures;
	int unsigned bytes_owed;
	int unsigned bytes_checked;

	// Percentages of cycles in which the sender holds back a request and the
	// receiver refuses one. They change from phase to phase.
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;

	int unsigned rx_bytes;
	int unsigned noise_bytes;
	int unsigned frames_sent;
	int unsigned good_frames;

	command_frame_receiver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.tx        (tx_ch)
	);

	cfr_response_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_valid      (rx_ch.valid),
		.rx_ready      (rx_ch.ready),
		.rx_byte       (rx_ch.rx_byte),
		.tx_valid      (tx_ch.valid),
		.tx_ready      (tx_ch.ready),
		.tx_byte       (tx_ch.tx_byte),
		.tx_last       (tx_ch.last_byte),
		.tx_action     (tx_ch.action),
		.failures      (failures),
		.bytes_owed    (bytes_owed),
		.bytes_checked (bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The response side decides afresh at every edge whether it takes a byte.
	always @(posedge clk) begin
		tx_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// Offers one received byte and returns at the edge where it is taken. An
	// idle stretch may come first; valid stays high into the next request when
	// the caller has another byte ready at once.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		rx_bytes++;
	endtask

	// Sends a whole command frame with random payload. A broken frame differs
	// from a good one only in the field named by the fault; an oversized
	// length stops the frame right after the length byte, since the block
	// goes back to header hunting at that point.
	task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len,
		input frame_fault_t fault);
		logic [BYTE_W-1:0] chk;
		logic [BYTE_W-1:0] pl;
		logic [BYTE_W-1:0] bad_tail;
		int                i;
		frames_sent++;
		chk = cmd + len;
		send_byte(HEAD_BYTE);
		send_byte(HEAD_BYTE);
		send_byte(cmd);
		send_byte(len);
		if (fault != FR_BIG_LEN) begin
			for (i = 0; i < len; i++) begin
				pl  = 8'($urandom_range(0, 255));
				chk = chk + pl;
				send_byte(pl);
			end
			// Any byte but the tail byte, the header byte included.
			bad_tail = 8'($urandom_range(0, 254));
			if (bad_tail >= TAIL_BYTE)
				bad_tail = bad_tail + 1'b1;
			if (fault == FR_BAD_SUM)
				chk = chk + 8'($urandom_range(1, 255));
			send_byte(chk);
			send_byte((fault == FR_BAD_TAIL1) ? bad_tail : TAIL_BYTE);
			send_byte((fault == FR_BAD_TAIL2) ? bad_tail : TAIL_BYTE);
			if (fault == FR_GOOD)
				good_frames++;
		end
	endtask

	// Line noise between frames, rich in header bytes so that lone and
	// tripled headers turn up by chance as well.
	task automatic send_noise(input int unsigned n);
		int unsigned i;
		for (i = 0; i < n; i++) begin
			send_byte(($urandom_range(0, 99) < 25) ? HEAD_BYTE : 8'($urandom_range(0, 255)));
			noise_bytes++;
		end
	endtask

	// Mostly well-formed frames with short payloads, now and then a long one,
	// a deliberately broken one or a burst of noise.
	task automatic random_frame();
		int unsigned       pick;
		logic [BYTE_W-1:0] cmd;
		logic [BYTE_W-1:0] len;
		frame_fault_t      fault;
		pick = $urandom_range(0, 99);
		cmd  = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
		len  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 8)) :
			8'($urandom_range(9, MAX_PAYLOAD));
		if (pick < 70) begin
			send_frame(cmd, len, FR_GOOD);
		end else if (pick < 85) begin
			fault = frame_fault_t'($urandom_range(1, 4));
			if (fault == FR_BIG_LEN)
				len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
			send_frame(cmd, len, fault);
		end else begin
			send_noise($urandom_range(1, 4));
		end
	endtask

	// Waits until every predicted response byte has come out, then lets the
	// block settle so that no request is still in flight. The first edge is
	// taken unconditionally because the checker only sees a frame's response
	// from the edge after its last byte was accepted.
	task automatic wait_for_responses();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (bytes_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both ID registers on consecutive edges. The upper half of the
	// data for the 32-bit register carries random bits that must be ignored.
	task automatic set_device_id(input logic [ID_HIGH_W-1:0] hi, input logic [ID_LOW_W-1:0] lo);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ID_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= REG_ID_LOW;
		cfg_data  <= {32'($urandom), lo};
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int                phase;
		int unsigned       phase_start;
		logic [BYTE_W-1:0] c;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_ID_HIGH;
		cfg_data      = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		tx_ch.ready   = 1'b0;
		src_idle_pct  = 34;
		sink_idle_pct = 49;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The ID query runs first on the reset value of the
		// ID registers, then on a written pattern with a received length that
		// the response must ignore.
		send_frame(ID_CMD, 8'd0, FR_GOOD);
		wait_for_responses();
		set_device_id(64'h0123_4567_89AB_CDEF, 32'h8967_4523);
		send_frame(ID_CMD, 8'd3, FR_GOOD);
		// Commands 1 to 4 carry an action code on the last byte, 5 carries none.
		for (c = 8'd1; c <= 8'd5; c++)
			send_frame(c, 8'd1, FR_GOOD);
		send_frame(8'hFF, 8'(MAX_PAYLOAD), FR_GOOD);
		send_frame(8'h07, 8'd0, FR_GOOD);
		// An oversized length drops the frame and hunting resumes at once.
		send_frame(8'h10, 8'(MAX_PAYLOAD + 1), FR_BIG_LEN);
		send_frame(8'h11, 8'd2, FR_GOOD);
		send_frame(8'h12, 8'hFF, FR_BIG_LEN);
		send_frame(8'h20, 8'd4, FR_BAD_SUM);
		send_frame(8'h21, 8'd4, FR_BAD_TAIL1);
		send_frame(8'h22, 8'd4, FR_BAD_TAIL2);
		// A lone header byte followed by anything else must not arm the parser.
		send_byte(HEAD_BYTE);
		send_byte(8'h13);
		// A header byte as command, then a tripled header whose third byte is
		// taken as the command, which shifts every later field of that frame.
		send_frame(HEAD_BYTE, 8'd2, FR_GOOD);
		send_byte(HEAD_BYTE);
		send_frame(8'h01, 8'd1, FR_GOOD);

		// Random part in three idle profiles, each with its own device ID.
		for (phase = 0; phase < 3; phase++) begin
			wait_for_responses();
			case (phase)
				0: begin
					src_idle_pct  = 34;
					sink_idle_pct = 49;
					set_device_id('1, '1);
				end
				1: begin
					src_idle_pct  = 49;
					sink_idle_pct = 34;
					set_device_id({32'($urandom), 32'($urandom)}, 32'($urandom));
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
					set_device_id({32'($urandom), 32'($urandom)}, 32'($urandom));
				end
			endcase
			phase_start = rx_bytes - noise_bytes;
			while (rx_bytes - noise_bytes - phase_start < PHASE_BYTES)
				random_frame();
		end

		wait_for_responses();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d received bytes (%0d noise) in %0d frames, %0d of them good,",
			rx_bytes, noise_bytes, frames_sent, good_frames);
		$display("under three idle profiles and five device IDs; %0d response bytes compared.",
			bytes_checked);
		if (failures == 0 && bytes_owed == 0) begin
			$display("** command_frame_receiver: PASSED **");
		end else begin
			$display("** command_frame_receiver: FAILED **");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run of this stimulus.
	initial begin
		#5000000;
		$display("Timeout with %0d response bytes still outstanding.", bytes_owed);
		$display("** command_frame_receiver: FAILED **");
		$finish;
	end

endmodule
